FILE: sv/bfhs_pkg.sv
// bfhs_pkg: shared constants, types and codes of the back/forward history stacks
// used by bfhs_ctrl, bfhs_dp and back_forward_history_stacks_top
package bfhs_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned PAGE_BITS   = 32;

  localparam int unsigned IDX_W   = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ID_W    = 32;
  localparam int unsigned ENTRY_W = 8;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned S_TUSER_W = ACT_W;
  localparam int unsigned M_TDATA_W = ID_W + 2 * ENTRY_W;
  localparam int unsigned M_TUSER_W = 1 + STAT_W;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_VISIT   = 2'd0,
    ACT_BACK    = 2'd1,
    ACT_FORWARD = 2'd2,
    ACT_SHOW    = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage

FILE: sv/bfhs_ctrl.sv
// bfhs_ctrl: sequencer for one command word, accept then update and result hand-off
// depends on bfhs_pkg
module bfhs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bfhs_pkg::cmd_t cmd_o
);
  import bfhs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   commit;

  assign commit = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.commit  = commit;
    out_valid_d   = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (commit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/bfhs_dp.sv
// bfhs_dp: page register, two stack memories with counts, and the result register
// depends on bfhs_pkg, driven by bfhs_ctrl commands
module bfhs_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfhs_pkg::cmd_t             cmd_i,
  input  logic [bfhs_pkg::ACT_W-1:0] action_i,
  input  logic [bfhs_pkg::ID_W-1:0]  page_id_i,
  output logic [bfhs_pkg::ID_W-1:0]  current_page_o,
  output logic                       page_valid_o,
  output logic [bfhs_pkg::STAT_W-1:0] status_o,
  output logic [bfhs_pkg::ENTRY_W-1:0] back_entries_o,
  output logic [bfhs_pkg::ENTRY_W-1:0] forward_entries_o
);
  import bfhs_pkg::*;

  page_t back_mem [STACK_DEPTH];
  page_t fwd_mem  [STACK_DEPTH];

  action_e act_q;
  page_t   pid_q;
  page_t   back_rd_q, fwd_rd_q;
  cnt_t    back_cnt_q, back_cnt_d, fwd_cnt_q, fwd_cnt_d;
  page_t   page_q, page_d;
  logic    has_q, has_d;
  status_e st;
  logic    back_we, fwd_we;
  logic    back_full, fwd_full;

  logic [ID_W-1:0]    out_page_q;
  logic               out_has_q;
  status_e            out_st_q;
  logic [ENTRY_W-1:0] out_back_q, out_fwd_q;

  assign back_full = (back_cnt_q == CNT_W'(STACK_DEPTH));
  assign fwd_full  = (fwd_cnt_q == CNT_W'(STACK_DEPTH));

  always_comb begin
    back_cnt_d = back_cnt_q;
    fwd_cnt_d  = fwd_cnt_q;
    page_d     = page_q;
    has_d      = has_q;
    st         = ST_OK;
    back_we    = 1'b0;
    fwd_we     = 1'b0;
    unique case (act_q)
      ACT_VISIT: begin
        if (has_q) begin
          if (back_full) begin
            st = ST_FULL;
          end else begin
            back_we    = 1'b1;
            back_cnt_d = back_cnt_q + cnt_t'(1);
          end
        end
        fwd_cnt_d = '0;
        page_d    = pid_q;
        has_d     = 1'b1;
      end
      ACT_BACK: begin
        if (back_cnt_q == '0) begin
          st = ST_EMPTY;
        end else begin
          if (has_q) begin
            if (fwd_full) begin
              st = ST_FULL;
            end else begin
              fwd_we    = 1'b1;
              fwd_cnt_d = fwd_cnt_q + cnt_t'(1);
            end
          end
          back_cnt_d = back_cnt_q - cnt_t'(1);
          page_d     = back_rd_q;
          has_d      = 1'b1;
        end
      end
      ACT_FORWARD: begin
        if (fwd_cnt_q == '0) begin
          st = ST_EMPTY;
        end else begin
          if (has_q) begin
            if (back_full) begin
              st = ST_FULL;
            end else begin
              back_we    = 1'b1;
              back_cnt_d = back_cnt_q + cnt_t'(1);
            end
          end
          fwd_cnt_d = fwd_cnt_q - cnt_t'(1);
          page_d    = fwd_rd_q;
          has_d     = 1'b1;
        end
      end
      ACT_SHOW: begin
      end
      default: begin
      end
    endcase
  end

  // stack memories, top read on accept, push written on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && back_we) back_mem[back_cnt_q[IDX_W-1:0]] <= page_q;
    if (cmd_i.load) back_rd_q <= back_mem[idx_t'(back_cnt_q - cnt_t'(1))];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && fwd_we) fwd_mem[fwd_cnt_q[IDX_W-1:0]] <= page_q;
    if (cmd_i.load) fwd_rd_q <= fwd_mem[idx_t'(fwd_cnt_q - cnt_t'(1))];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_e'(action_i);
      pid_q <= page_t'(page_id_i);
    end
    if (cmd_i.commit) begin
      out_page_q <= has_d ? ID_W'(page_d) : '0;
      out_has_q  <= has_d;
      out_st_q   <= st;
      out_back_q <= ENTRY_W'(back_cnt_d);
      out_fwd_q  <= ENTRY_W'(fwd_cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_cnt_q <= '0;
      fwd_cnt_q  <= '0;
      page_q     <= '0;
      has_q      <= 1'b0;
    end else if (cmd_i.commit) begin
      back_cnt_q <= back_cnt_d;
      fwd_cnt_q  <= fwd_cnt_d;
      page_q     <= page_d;
      has_q      <= has_d;
    end
  end

  assign current_page_o    = out_page_q;
  assign page_valid_o      = out_has_q;
  assign status_o          = out_st_q;
  assign back_entries_o    = out_back_q;
  assign forward_entries_o = out_fwd_q;

  a_back_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("back count past depth");

  a_fwd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("forward count past depth");

  a_visit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && act_q == ACT_VISIT) |=> (fwd_cnt_q == '0 && has_q))
    else $error("visit left forward entries");

  a_empty_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && st == ST_EMPTY) |=>
      ($stable(back_cnt_q) && $stable(fwd_cnt_q) && $stable(page_q)))
    else $error("empty move changed state");

endmodule

FILE: sv/back_forward_history_stacks_top.sv
// back_forward_history_stacks_top: stream wrapper of the back/forward page history
// depends on bfhs_pkg, bfhs_ctrl and bfhs_dp
//
// One command word (tuser = action, tdata = page id) gives one result word. A command
// has an accept step and an exec step: the accept step reads both stack tops from the
// synchronous stack memories, the exec step pushes, updates counts and page, and loads
// the output register once that register is free. A new word is accepted only after the
// last one is done; a held result stalls only the update of the next word. Stacks hold 128
// pages each and need no clearing after reset, entries above the counts are never used.
module back_forward_history_stacks_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bfhs_pkg::S_TDATA_W-1:0] s_axis_tdata,  // page_id
  input  logic [bfhs_pkg::S_TUSER_W-1:0] s_axis_tuser,  // action
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bfhs_pkg::M_TDATA_W-1:0] m_axis_tdata,  // current_page, back_entries, forward_entries
  output logic [bfhs_pkg::M_TUSER_W-1:0] m_axis_tuser   // page_valid, status
);
  import bfhs_pkg::*;

  cmd_t               cmd;
  logic [ID_W-1:0]    current_page;
  logic               page_valid;
  logic [STAT_W-1:0]  status;
  logic [ENTRY_W-1:0] back_entries;
  logic [ENTRY_W-1:0] forward_entries;

  bfhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bfhs_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .action_i          (s_axis_tuser),
    .page_id_i         (s_axis_tdata[ID_W-1:0]),
    .current_page_o    (current_page),
    .page_valid_o      (page_valid),
    .status_o          (status),
    .back_entries_o    (back_entries),
    .forward_entries_o (forward_entries)
  );

  assign m_axis_tdata = {forward_entries, back_entries, current_page};
  assign m_axis_tuser = {status, page_valid};

endmodule

FILE: tb/back_forward_history_stacks_chk.sv
// back_forward_history_stacks_chk: watches both stream channels of the page history,
// predicts each result word from the command words and compares them field by field
// depends on bfhs_pkg
`timescale 1ns / 100ps

module back_forward_history_stacks_chk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [bfhs_pkg::S_TDATA_W-1:0] s_axis_tdata,   // page_id
  input  logic [bfhs_pkg::S_TUSER_W-1:0] s_axis_tuser,   // action
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // current_page, back_entries, forward_entries
  input  logic [bfhs_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic [bfhs_pkg::M_TUSER_W-1:0] m_axis_tuser,   // page_valid, status
  output int                             mismatch_cnt_o,
  output int                             pending_o
);
  import bfhs_pkg::*;

  localparam int BACK_STK = 0;
  localparam int FWD_STK  = 1;

  typedef struct {
    page_t              page;
    logic               valid;
    status_e            status;
    logic [ENTRY_W-1:0] back_n;
    logic [ENTRY_W-1:0] fwd_n;
  } page_view_t;

  page_t       stk_pages [2][STACK_DEPTH];
  int unsigned stk_depth [2];
  page_t       cur_page;
  logic        have_page;
  page_view_t  expected_views[$];
  int          mismatch_cnt;

  assign mismatch_cnt_o = mismatch_cnt;

  initial mismatch_cnt = 0;

  function automatic status_e push_page(int dst, page_t pg);
    if (stk_depth[dst] >= STACK_DEPTH) return ST_FULL;
    stk_pages[dst][stk_depth[dst]] = pg;
    stk_depth[dst]++;
    return ST_OK;
  endfunction

  function automatic status_e move_page(int src, int dst);
    status_e st;
    st = ST_OK;
    if (stk_depth[src] == 0) return ST_EMPTY;
    if (have_page) st = push_page(dst, cur_page);
    stk_depth[src]--;
    cur_page  = stk_pages[src][stk_depth[src]];
    have_page = 1'b1;
    return st;
  endfunction

  function automatic page_view_t navigate_history(action_e act, page_t pid);
    page_view_t v;
    status_e    st;
    st = ST_OK;
    case (act)
      ACT_VISIT: begin
        if (have_page) st = push_page(BACK_STK, cur_page);
        stk_depth[FWD_STK] = 0;
        cur_page  = pid;
        have_page = 1'b1;
      end
      ACT_BACK:    st = move_page(BACK_STK, FWD_STK);
      ACT_FORWARD: st = move_page(FWD_STK, BACK_STK);
      default: ;
    endcase
    v.page   = have_page ? cur_page : '0;
    v.valid  = have_page;
    v.status = st;
    v.back_n = ENTRY_W'(stk_depth[BACK_STK]);
    v.fwd_n  = ENTRY_W'(stk_depth[FWD_STK]);
    return v;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatch_cnt++;
    $display("%0t mismatch %s: expected %0h got %0h", $time, field, want, got);
  endtask

  task automatic check_view();
    page_view_t exp_v;
    if (expected_views.size() == 0) begin
      report_mismatch("unexpected result word", '0, 64'(m_axis_tdata));
      return;
    end
    exp_v = expected_views.pop_front();
    if (m_axis_tdata[ID_W-1:0] !== exp_v.page)
      report_mismatch("current_page", 64'(exp_v.page), 64'(m_axis_tdata[ID_W-1:0]));
    if (m_axis_tuser[0] !== exp_v.valid)
      report_mismatch("page_valid", 64'(exp_v.valid), 64'(m_axis_tuser[0]));
    if (m_axis_tuser[STAT_W:1] !== exp_v.status)
      report_mismatch("status", 64'(exp_v.status), 64'(m_axis_tuser[STAT_W:1]));
    if (m_axis_tdata[ID_W +: ENTRY_W] !== exp_v.back_n)
      report_mismatch("back_entries", 64'(exp_v.back_n),
                      64'(m_axis_tdata[ID_W +: ENTRY_W]));
    if (m_axis_tdata[ID_W+ENTRY_W +: ENTRY_W] !== exp_v.fwd_n)
      report_mismatch("forward_entries", 64'(exp_v.fwd_n),
                      64'(m_axis_tdata[ID_W+ENTRY_W +: ENTRY_W]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stk_depth[BACK_STK] = 0;
      stk_depth[FWD_STK]  = 0;
      cur_page            = '0;
      have_page           = 1'b0;
      expected_views.delete();
      pending_o <= 0;
    end else begin
      // a result always leaves after its command was accepted, so check before adding
      if (m_axis_tvalid && m_axis_tready) check_view();
      if (s_axis_tvalid && s_axis_tready)
        expected_views.push_back(navigate_history(action_e'(s_axis_tuser), s_axis_tdata));
      pending_o <= expected_views.size();
    end
  end

endmodule

FILE: tb/back_forward_history_stacks_top_tb.sv
// back_forward_history_stacks_top_tb: drives command words into the page history
// under several idling patterns and long output hold-offs, and gives the verdict
// depends on bfhs_pkg, back_forward_history_stacks_top and back_forward_history_stacks_chk
`timescale 1ns / 100ps

module back_forward_history_stacks_top_tb;
  import bfhs_pkg::*;

  localparam int RAND_WORDS = 1000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // page_id
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;   // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;         // current_page, back_entries, forward_entries
  logic [M_TUSER_W-1:0] m_axis_tuser;         // page_valid, status

  int mismatch_cnt;
  int words_in_flight;
  int words_sent = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_seq   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  back_forward_history_stacks_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  back_forward_history_stacks_chk u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (words_in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= $urandom_range(80, 50);
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input action_e act, input page_t pid);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= pid;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic page_t pick_page();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic action_e pick_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return ACT_VISIT;
    if (r < 65) return ACT_BACK;
    if (r < 90) return ACT_FORWARD;
    return ACT_SHOW;
  endfunction

  // long visit run overflows the back stack, then walk back and forth
  task automatic fill_history();
    repeat ($urandom_range(140, 130)) send_word(ACT_VISIT, pick_page());
    repeat ($urandom_range(135, 20)) send_word(ACT_BACK, pick_page());
    repeat ($urandom_range(135, 10)) send_word(ACT_FORWARD, pick_page());
  endtask

  initial begin
    int idle_tab [4];
    int stall_tab[4];
    int phase_end;
    idle_tab  = '{0, 61, 0, 30};
    stall_tab = '{0, 0, 61, 30};
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty history, then extreme ids and walks off both ends
    send_word(ACT_SHOW, '0);
    send_word(ACT_BACK, '1);
    send_word(ACT_FORWARD, '0);
    send_word(ACT_VISIT, '0);
    send_word(ACT_VISIT, '1);
    send_word(ACT_VISIT, 32'hA5A5_A5A5);
    send_word(ACT_BACK, '0);
    send_word(ACT_BACK, '0);
    send_word(ACT_BACK, '1);
    send_word(ACT_FORWARD, '0);
    send_word(ACT_FORWARD, '0);
    send_word(ACT_FORWARD, '1);
    send_word(ACT_BACK, '0);
    send_word(ACT_VISIT, 32'h5A5A_5A5A);
    send_word(ACT_FORWARD, '0);
    send_word(ACT_SHOW, '1);
    send_word(ACT_VISIT, 32'h1234_5678);
    send_word(ACT_BACK, '0);
    send_word(ACT_BACK, '0);
    send_word(ACT_BACK, '0);
    send_word(ACT_SHOW, '0);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct <= stall_tab[p];
      hold_seq  <= hold_seq + 1;
      phase_end = words_sent + RAND_WORDS / 4;
      if (p == 0 || p == 3) fill_history();
      while (words_sent < phase_end) begin
        if ($urandom_range(9) == 0) begin
          fill_history();
        end else begin
          repeat ($urandom_range(40, 10)) send_word(pick_action(), pick_page());
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_in_flight != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
